@@ sv/rc4_pkg.sv @@
// shared types and constants for the rc4 keystream cipher
package rc4_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SBOX_DEPTH  = 256;
  localparam int unsigned KEY_REG_W   = 64;
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_KEY_LOW  = 2'd0;
  localparam cfg_addr_t REG_KEY_HIGH = 2'd1;
  localparam cfg_addr_t REG_KEY_LEN  = 2'd2;

  localparam logic CMD_REKEY = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_J,
    ST_KS_WR_N,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_WR_J,
    ST_GEN_WR_I,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FILL,
    OP_KS_RD_N,
    OP_KS_RD_J,
    OP_KS_WR_J,
    OP_KS_WR_N,
    OP_GEN_RD_I,
    OP_GEN_RD_J,
    OP_GEN_WR_J,
    OP_GEN_WR_I,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic keyed;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/rc4_ctrl.sv @@
// sequencer for key schedule and keystream generation
module rc4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  input  rc4_pkg::dp_stat_t stat,
  output rc4_pkg::dp_cmd_t  cmd
);
  import rc4_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_ACCEPT;
          if (in_cmd == CMD_REKEY) begin
            state_nxt = ST_FILL;
          end else if (stat.keyed) begin
            state_nxt = ST_GEN_RD_I;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (stat.cnt_last) begin
          state_nxt = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        cmd.op    = OP_KS_RD_N;
        state_nxt = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        cmd.op    = OP_KS_RD_J;
        state_nxt = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        cmd.op    = OP_KS_WR_J;
        state_nxt = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        cmd.op    = OP_KS_WR_N;
        state_nxt = stat.cnt_last ? ST_IDLE : ST_KS_RD_N;
      end
      ST_GEN_RD_I: begin
        cmd.op    = OP_GEN_RD_I;
        state_nxt = ST_GEN_RD_J;
      end
      ST_GEN_RD_J: begin
        cmd.op    = OP_GEN_RD_J;
        state_nxt = ST_GEN_WR_J;
      end
      ST_GEN_WR_J: begin
        cmd.op    = OP_GEN_WR_J;
        state_nxt = ST_GEN_WR_I;
      end
      ST_GEN_WR_I: begin
        cmd.op    = OP_GEN_WR_I;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/rc4_dp.sv @@
// permutation memory, indices, key registers and result register
module rc4_dp #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  rc4_pkg::cfg_addr_t              cfg_addr,
  input  logic [rc4_pkg::KEY_REG_W-1:0]   cfg_wdata,
  input  logic [rc4_pkg::IN_DATA_W-1:0]   in_tdata,
  input  rc4_pkg::dp_cmd_t                cmd,
  output rc4_pkg::dp_stat_t               stat,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [rc4_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser
);
  import rc4_pkg::*;

  localparam int unsigned KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  byte_t sbox [SBOX_DEPTH];

  logic [KEY_REG_W-1:0] key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0] key_len_r;
  logic                 keyed_r, keyed_nxt;
  byte_t                i_r, i_nxt;
  byte_t                j_r, j_nxt;
  byte_t                cnt_r, cnt_nxt;
  logic [KIW-1:0]       kidx_r, kidx_nxt;
  byte_t                si_r, si_nxt;
  byte_t                sj_r, sj_nxt;
  byte_t                tadr_r, tadr_nxt;
  byte_t                data_r, data_nxt;
  byte_t                rdata_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                 out_user_r, out_user_nxt;

  logic                 rd_en, wr_en;
  byte_t                rd_addr, wr_addr, wr_data;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [2*KEY_REG_W-1:0] key_all;
  byte_t                key_byte;
  byte_t                ks;
  logic                 kidx_last;

  // key configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_LOW:  key_lo_r  <= cfg_wdata;
        REG_KEY_HIGH: key_hi_r  <= cfg_wdata;
        REG_KEY_LEN:  key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (key_len_r == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_len_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = key_len_r;
    end
  end

  assign key_all   = {key_hi_r, key_lo_r};
  assign key_byte  = key_all[{kidx_r, 3'b000} +: BYTE_W];
  assign kidx_last = (KEY_LEN_W'(kidx_r) + KEY_LEN_W'(1)) == len_eff;

  // newly written S[i] is not yet visible to the read issued with it
  assign ks = (tadr_r == i_r) ? sj_r : rdata_r;

  always_comb begin
    keyed_nxt     = keyed_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    kidx_nxt      = kidx_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    tadr_nxt      = tadr_r;
    data_nxt      = data_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    rd_en         = 1'b0;
    rd_addr       = cnt_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r;
    wr_data       = cnt_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_ACCEPT: begin
        data_nxt = in_tdata;
      end
      OP_FILL: begin
        wr_en    = 1'b1;
        cnt_nxt  = cnt_r + 8'd1;
        j_nxt    = '0;
        kidx_nxt = '0;
      end
      OP_KS_RD_N: begin
        rd_en = 1'b1;
      end
      OP_KS_RD_J: begin
        si_nxt   = rdata_r;
        j_nxt    = j_r + rdata_r + key_byte;
        rd_en    = 1'b1;
        rd_addr  = j_nxt;
        kidx_nxt = kidx_last ? '0 : kidx_r + KIW'(1);
      end
      OP_KS_WR_J: begin
        sj_nxt  = rdata_r;
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = si_r;
      end
      OP_KS_WR_N: begin
        wr_en   = 1'b1;
        wr_data = sj_r;
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'(SBOX_DEPTH - 1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
        end
      end
      OP_GEN_RD_I: begin
        i_nxt   = i_r + 8'd1;
        rd_en   = 1'b1;
        rd_addr = i_nxt;
      end
      OP_GEN_RD_J: begin
        si_nxt  = rdata_r;
        j_nxt   = j_r + rdata_r;
        rd_en   = 1'b1;
        rd_addr = j_nxt;
      end
      OP_GEN_WR_J: begin
        sj_nxt  = rdata_r;
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = si_r;
      end
      OP_GEN_WR_I: begin
        wr_en    = 1'b1;
        wr_addr  = i_r;
        wr_data  = sj_r;
        tadr_nxt = si_r + sj_r;
        rd_en    = 1'b1;
        rd_addr  = tadr_nxt;
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        if (keyed_r) begin
          out_data_nxt = {ks, data_r ^ ks};
          out_user_nxt = 1'b0;
        end else begin
          out_data_nxt = {8'd0, data_r};
          out_user_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sbox[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= sbox[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyed_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      kidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      keyed_r     <= keyed_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      kidx_r      <= kidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    tadr_r     <= tadr_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign stat.keyed    = keyed_r;
  assign stat.cnt_last = (cnt_r == 8'(SBOX_DEPTH - 1));
  assign stat.out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ sv/rc4_keystream_cipher.sv @@
// top level of the rc4 keystream cipher
// data request: read i, read j, write j, write i, then output registers the result when free
// data request before any rekey: passed through, result registered from the output state
// rekey request: identity fill of 256 entries, then read n, read j, write j, write n per entry
// the permutation memory read is registered; a new request is taken only back in idle
// rst_n is synchronous: indices, key bytes and keyed flag clear, key length returns to 16
module rc4_keystream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  rc4_pkg::cfg_addr_t              cfg_addr,
  input  logic [rc4_pkg::KEY_REG_W-1:0]   cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rc4_pkg::IN_DATA_W-1:0]   in_tdata,   // data_byte
  input  logic                            in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rc4_pkg::OUT_DATA_W-1:0]  out_tdata,  // out_byte, keystream_byte
  output logic                            out_tuser   // not_keyed
);
  import rc4_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/rc4_chk.sv @@
// port-level checks for the rc4 keystream cipher
module rc4_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rc4_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tuser
);
  import rc4_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_pass_no_ks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:8] == 8'd0)
    else $error("unkeyed result carries keystream");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

endmodule

bind rc4_keystream_cipher rc4_chk u_rc4_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/tb_top.sv @@
// self-checking testbench for the rc4 keystream cipher: random key settings, data and rekey traffic
`timescale 1ns / 100ps

module tb_top;
  import rc4_pkg::*;

  localparam int unsigned KEY_BYTES_MAX = 16;
  localparam int unsigned SETTLE_CYCLES = 1400;
  localparam cfg_addr_t   REG_UNMAPPED  = 2'd3;

  typedef struct {
    logic  cmd;
    byte_t data;
  } cipher_req_t;

  typedef struct {
    byte_t out_byte;
    byte_t keystream_byte;
    logic  not_keyed;
  } cipher_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_addr_t             cfg_addr = REG_KEY_LOW;
  logic [KEY_REG_W-1:0]  cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // data_byte
  logic                  in_tuser = CMD_DATA;   // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // out_byte, keystream_byte
  logic                  out_tuser;  // not_keyed

  cipher_req_t    cipher_req_q[$];
  cipher_result_t cipher_results_q[$];

  byte_t          sbox_model[SBOX_DEPTH];
  byte_t          model_i;
  byte_t          model_j;
  logic           model_keyed;
  logic [63:0]    model_key_lo;
  logic [63:0]    model_key_hi;
  logic [4:0]     model_key_len;

  int unsigned    fail_count;
  int unsigned    req_count;
  int unsigned    rekey_count;
  int unsigned    result_count;
  int unsigned    setting_count;
  int unsigned    burst_left;
  int unsigned    gap_left;
  int unsigned    ready_run;
  int unsigned    stall_run;
  int unsigned    hold_left;

  rc4_keystream_cipher #(.MAX_KEY_BYTES(KEY_BYTES_MAX)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic rc4_predict(input logic cmd, input byte_t data);
    cipher_result_t res;
    int unsigned    len;
    byte_t          acc;
    byte_t          kb;
    byte_t          tmp;
    byte_t          sum;
    if (cmd == CMD_REKEY) begin
      len = model_key_len;
      if (len == 0) len = 1;
      if (len > KEY_BYTES_MAX) len = KEY_BYTES_MAX;
      for (int n = 0; n < SBOX_DEPTH; n++) sbox_model[n] = byte_t'(n);
      acc = '0;
      for (int n = 0; n < SBOX_DEPTH; n++) begin
        kb = ((n % len) < 8) ? model_key_lo[8*(n % len) +: 8]
                             : model_key_hi[8*((n % len) - 8) +: 8];
        acc = acc + sbox_model[n] + kb;
        tmp = sbox_model[acc];
        sbox_model[acc] = sbox_model[n];
        sbox_model[n] = tmp;
      end
      model_i = '0;
      model_j = '0;
      model_keyed = 1'b1;
      rekey_count++;
    end else if (!model_keyed) begin
      res = '{data, 8'h00, 1'b1};
      cipher_results_q.push_back(res);
    end else begin
      model_i = model_i + 8'd1;
      model_j = model_j + sbox_model[model_i];
      tmp = sbox_model[model_j];
      sbox_model[model_j] = sbox_model[model_i];
      sbox_model[model_i] = tmp;
      sum = sbox_model[model_i] + sbox_model[model_j];
      res = '{data ^ sbox_model[sum], sbox_model[sum], 1'b0};
      cipher_results_q.push_back(res);
    end
  endtask

  task automatic write_reg(input cfg_addr_t addr, input logic [KEY_REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      REG_KEY_LOW:  model_key_lo = val;
      REG_KEY_HIGH: model_key_hi = val;
      REG_KEY_LEN:  model_key_len = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cipher_req_q.size() != 0 || in_tvalid || cipher_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_req(input logic cmd, input byte_t data);
    cipher_req_t req;
    req = '{cmd, data};
    cipher_req_q.push_back(req);
  endtask

  task automatic queue_random_phase(input int unsigned n);
    logic cmd;
    for (int k = 0; k < n; k++) begin
      if (k == 0) cmd = ($urandom_range(0, 3) != 0) ? CMD_REKEY : CMD_DATA;
      else cmd = ($urandom_range(0, 39) == 0) ? CMD_REKEY : CMD_DATA;
      push_req(cmd, byte_t'($urandom_range(0, 255)));
    end
  endtask

  // sender: bursts of requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rc4_predict(in_tuser, in_tdata);
        req_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cipher_req_q.size() != 0) begin
          cipher_req_t req;
          req = cipher_req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= req.cmd;
          in_tdata  <= req.data;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_run = 0;
      stall_run = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        cipher_result_t want;
        result_count++;
        if (cipher_results_q.size() == 0) begin
          $error("unexpected result: out_tdata %0h out_tuser %0b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = cipher_results_q.pop_front();
          if (out_tdata[7:0] !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[15:8] !== want.keystream_byte) begin
            $error("keystream_byte: expected %0h, got %0h", want.keystream_byte,
                   out_tdata[15:8]);
            fail_count++;
          end
          if (out_tuser !== want.not_keyed) begin
            $error("not_keyed: expected %0b, got %0b", want.not_keyed, out_tuser);
            fail_count++;
          end
        end
        if (result_count == 60 || result_count == 300) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        out_tready <= 1'b0;
      end else if (ready_run > 0) begin
        ready_run--;
        out_tready <= 1'b1;
      end else begin
        ready_run = $urandom_range(1, 40);
        stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [4:0] len;
    for (int n = 0; n < SBOX_DEPTH; n++) sbox_model[n] = '0;
    model_i       = '0;
    model_j       = '0;
    model_keyed   = 1'b0;
    model_key_lo  = '0;
    model_key_hi  = '0;
    model_key_len = KEY_LEN_RESET;
    fail_count    = 0;
    req_count     = 0;
    rekey_count   = 0;
    result_count  = 0;
    setting_count = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // pass-through before any key schedule, then reset key settings
    push_req(CMD_DATA, 8'h00);
    push_req(CMD_DATA, 8'hFF);
    push_req(CMD_DATA, 8'h96);
    push_req(CMD_REKEY, 8'hFF);
    push_req(CMD_DATA, 8'h00);
    push_req(CMD_DATA, 8'hFF);
    push_req(CMD_DATA, 8'h5A);
    push_req(CMD_DATA, 8'h3C);
    push_req(CMD_DATA, 8'h01);
    push_req(CMD_DATA, 8'h80);
    wait_idle();

    // all-ones key, zero length, unmapped register
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LEN, 64'd0);
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    setting_count++;
    push_req(CMD_REKEY, 8'h00);
    push_req(CMD_DATA, 8'h00);
    push_req(CMD_DATA, 8'hFF);
    push_req(CMD_DATA, 8'h11);
    wait_idle();

    // length above the maximum, rekey mid-stream
    write_reg(REG_KEY_LOW, 64'h0706050403020100);
    write_reg(REG_KEY_HIGH, 64'h0F0E0D0C0B0A0908);
    write_reg(REG_KEY_LEN, 64'd31);
    setting_count++;
    push_req(CMD_REKEY, 8'h00);
    push_req(CMD_DATA, 8'hC3);
    push_req(CMD_DATA, 8'h3C);
    push_req(CMD_DATA, 8'hFF);
    push_req(CMD_REKEY, 8'h7E);
    push_req(CMD_DATA, 8'h00);
    push_req(CMD_DATA, 8'hAA);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case ($urandom_range(0, 5))
        0:       len = 5'd0;
        1:       len = 5'd1;
        2:       len = 5'd16;
        3:       len = 5'd31;
        4:       len = 5'd17;
        default: len = 5'($urandom_range(2, 15));
      endcase
      write_reg(REG_KEY_LOW, {$urandom, $urandom});
      write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      write_reg(REG_KEY_LEN, 64'(len));
      setting_count++;
      queue_random_phase(70);
      wait_idle();
    end

    $display("covered %0d requests including %0d key schedules over %0d key settings",
             req_count, rekey_count, setting_count);
    $display("checked %0d results, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rc4_pkg.sv
sv/rc4_ctrl.sv
sv/rc4_dp.sv
sv/rc4_keystream_cipher.sv
sv/rc4_chk.sv
verif/tb_top.sv
